// ----- design/differential_drive_odometry_top_macros.svh -----
// assertion macros used by the odometry top module
`ifndef DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`define DIFFERENTIAL_DRIVE_ODOMETRY_TOP_MACROS_SVH
`ifndef SYNTH
`define ODO_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("odometry assertion failed");
`define ODO_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("odometry assertion failed");
`else
`define ODO_ASSERT(lbl, prop)
`define ODO_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ----- design/odo_pkg.sv -----
// constants and arctangent table for the odometry block
package odo_pkg;
	localparam int POSITION_BITS_DEF = 32;
	localparam int ANGLE_BITS_DEF = 24;
	localparam int CORDIC_ITERATIONS_DEF = 20;
	localparam int STEP_W = 16;
	localparam int GAIN_W = 20;
	localparam logic [GAIN_W-1:0] GAIN_RESET = 20'd70956;
	localparam int OUT_POS_W = 32;
	localparam int OUT_ANG_W = 24;
	// cordic datapath width, q2.30 plus guard bits
	localparam int CORDIC_W = 34;
	localparam logic signed [CORDIC_W-1:0] CORDIC_K = 34'sd652032874;
	localparam int ATAN_IDX_W = 5;

	// arctangent of 2^-i in 2^-32 turn
	function automatic logic [31:0] atan_turn(input logic [ATAN_IDX_W-1:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'd536870912;
			5'd1: v = 32'd316933406;
			5'd2: v = 32'd167458907;
			5'd3: v = 32'd85004756;
			5'd4: v = 32'd42667331;
			5'd5: v = 32'd21354465;
			5'd6: v = 32'd10680862;
			5'd7: v = 32'd5340245;
			5'd8: v = 32'd2670163;
			5'd9: v = 32'd1335087;
			5'd10: v = 32'd667544;
			5'd11: v = 32'd333772;
			5'd12: v = 32'd166886;
			5'd13: v = 32'd83443;
			5'd14: v = 32'd41722;
			5'd15: v = 32'd20861;
			5'd16: v = 32'd10430;
			5'd17: v = 32'd5215;
			5'd18: v = 32'd2608;
			5'd19: v = 32'd1304;
			5'd20: v = 32'd652;
			5'd21: v = 32'd326;
			5'd22: v = 32'd163;
			5'd23: v = 32'd81;
			5'd24: v = 32'd41;
			5'd25: v = 32'd20;
			5'd26: v = 32'd10;
			5'd27: v = 32'd5;
			5'd28: v = 32'd3;
			5'd29: v = 32'd1;
			default: v = 32'd0;
		endcase
		return v;
	endfunction
endpackage

// ----- design/differential_drive_odometry_top.sv -----
// differential drive odometry: pose update per wheel sample
// Usage:
//   s_tdata carries one wheel sample per item (left step, right step);
//   s_tuser set clears the pose to zero before the sample is applied.
//   m_tdata returns the updated pose (x, y, heading) once per input item.
//   cfg_we/cfg_wdata write the turn gain; write only while the block is idle.
// Sequence:
//   an item runs the cordic, then the bit-serial multiplies for x and y
//   side by side, then the commit into the pose and the output register.
//   The turn product runs in parallel with the cordic.
//   One item at a time: the next item is taken only once the previous one
//   has been committed.
// Reset:
//   pose clears to zero, turn gain returns to its default (0.147 m track).
// Stall:
//   a finished result waits in the output register; the next item may be
//   accepted meanwhile, and its commit waits until the output slot is free.
module differential_drive_odometry_top #(
	parameter int POSITION_BITS = odo_pkg::POSITION_BITS_DEF,
	parameter int ANGLE_BITS = odo_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,   // left_step, right_step
	input  logic                        s_tuser,   // restart
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [87:0]                 m_tdata,   // x_position, y_position, heading
	input  logic                        cfg_we,
	input  logic [odo_pkg::GAIN_W-1:0]  cfg_wdata
);
	import odo_pkg::*;

	`include "differential_drive_odometry_top_macros.svh"

	localparam int SUM_W = STEP_W + 1;
	localparam int GA_W = GAIN_W + 1;
	localparam int GP_W = GA_W + SUM_W;
	localparam int XP_W = CORDIC_W + SUM_W;
	localparam int D_W = XP_W - 31;
	localparam int ACC_W = POSITION_BITS + 2;

	typedef enum logic [1:0] {ST_IDLE, ST_TRIG, ST_MUL, ST_OUT} state_t;

	state_t                         state_q;
	logic [GAIN_W-1:0]              gain_q;
	logic signed [POSITION_BITS-1:0] pose_x_q, pose_y_q;
	logic [ANGLE_BITS-1:0]          pose_h_q;
	logic signed [SUM_W-1:0]        sum_q, diff_s1;
	logic                           m_tvalid_q;
	logic [87:0]                    m_tdata_q;

	logic                           accept, start_xy, commit;
	logic signed [STEP_W-1:0]       left_in, right_in;
	logic [ANGLE_BITS-1:0]          old_heading;
	logic                           trig_done, gain_done, x_done, y_done;
	logic signed [CORDIC_W-1:0]     cos_v, sin_v;
	logic signed [GP_W-1:0]         gain_prod, gain_rnd;
	logic signed [XP_W-1:0]         x_prod, y_prod, x_rnd, y_rnd;
	logic signed [D_W-1:0]          dx, dy;
	logic signed [ACC_W-1:0]        x_sum, y_sum;
	logic signed [POSITION_BITS-1:0] x_new, y_new;
	logic [ANGLE_BITS-1:0]          h_new;
	logic signed [ACC_W-1:0]        pos_max, pos_min;

	assign accept = s_tvalid && s_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign left_in = $signed(s_tdata[15:0]);
	assign right_in = $signed(s_tdata[31:16]);
	assign old_heading = s_tuser ? '0 : pose_h_q;
	assign start_xy = (state_q == ST_TRIG) && trig_done;
	assign commit = (state_q == ST_OUT) && (!m_tvalid_q || m_tready);

	// cos and sin of the heading before the sample
	odo_cordic #(
		.ANGLE_BITS(ANGLE_BITS),
		.CORDIC_ITERATIONS(CORDIC_ITERATIONS)
	) u_cordic (
		.clk(clk), .arst_n(arst_n), .start(accept), .angle(old_heading),
		.done(trig_done), .cos_out(cos_v), .sin_out(sin_v)
	);

	// turn gain times wheel difference
	odo_serial_mult #(.A_W(GA_W), .B_W(SUM_W)) u_gain_mult (
		.clk(clk), .arst_n(arst_n), .start(accept),
		.a($signed({1'b0, gain_q})),
		.b(SUM_W'(left_in) - SUM_W'(right_in)),
		.done(gain_done), .product(gain_prod)
	);

	// travel times cos and sin
	odo_serial_mult #(.A_W(CORDIC_W), .B_W(SUM_W)) u_x_mult (
		.clk(clk), .arst_n(arst_n), .start(start_xy), .a(cos_v), .b(sum_q),
		.done(x_done), .product(x_prod)
	);
	odo_serial_mult #(.A_W(CORDIC_W), .B_W(SUM_W)) u_y_mult (
		.clk(clk), .arst_n(arst_n), .start(start_xy), .a(sin_v), .b(sum_q),
		.done(y_done), .product(y_prod)
	);

	// rounding, saturation and heading wrap
	assign gain_rnd = (gain_prod + GP_W'(128)) >>> 8;
	assign h_new = pose_h_q + ANGLE_BITS'(gain_rnd);
	assign x_rnd = (x_prod + (XP_W'(1) <<< 30)) >>> 31;
	assign y_rnd = (y_prod + (XP_W'(1) <<< 30)) >>> 31;
	assign dx = D_W'(x_rnd);
	assign dy = D_W'(y_rnd);
	assign x_sum = ACC_W'(pose_x_q) + ACC_W'(dx);
	assign y_sum = ACC_W'(pose_y_q) + ACC_W'(dy);
	assign pos_max = (ACC_W'(1) <<< (POSITION_BITS - 1)) - ACC_W'(1);
	assign pos_min = -pos_max - ACC_W'(1);

	always_comb begin
		if (x_sum > pos_max) x_new = POSITION_BITS'(pos_max);
		else if (x_sum < pos_min) x_new = POSITION_BITS'(pos_min);
		else x_new = POSITION_BITS'(x_sum);
		if (y_sum > pos_max) y_new = POSITION_BITS'(pos_max);
		else if (y_sum < pos_min) y_new = POSITION_BITS'(pos_min);
		else y_new = POSITION_BITS'(y_sum);
	end

	// sample capture
	always_ff @(posedge clk) begin
		if (accept) begin
			sum_q <= SUM_W'(left_in) + SUM_W'(right_in);
			diff_s1 <= SUM_W'(left_in) - SUM_W'(right_in);
		end
	end

	// turn gain register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q <= GAIN_RESET;
		end else if (cfg_we) begin
			gain_q <= cfg_wdata;
		end
	end

	// sequencer, pose and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			pose_x_q <= '0;
			pose_y_q <= '0;
			pose_h_q <= '0;
			m_tvalid_q <= 1'b0;
			m_tdata_q <= '0;
		end else begin
			if (m_tvalid_q && m_tready && !commit) m_tvalid_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						if (s_tuser) begin
							pose_x_q <= '0;
							pose_y_q <= '0;
							pose_h_q <= '0;
						end
						state_q <= ST_TRIG;
					end
				end
				ST_TRIG: begin
					if (trig_done) state_q <= ST_MUL;
				end
				ST_MUL: begin
					if (x_done) state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (commit) begin
						pose_x_q <= x_new;
						pose_y_q <= y_new;
						pose_h_q <= h_new;
						m_tvalid_q <= 1'b1;
						m_tdata_q <= {OUT_ANG_W'(h_new), OUT_POS_W'(y_new),
							OUT_POS_W'(x_new)};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	`ODO_ASSERT(a_xy_together, x_done == y_done)
	`ODO_ASSERT(a_trig_in_phase, !trig_done || state_q == ST_TRIG)
	`ODO_ASSERT(a_gain_before_xy, !start_xy || !gain_done)
	`ODO_ASSERT_NEXT(a_no_overlap, accept, !s_tready)
	`ODO_ASSERT_NEXT(a_diff_held, state_q != ST_IDLE, $stable(diff_s1))
endmodule

// ----- design/odo_serial_mult.sv -----
// bit-serial signed multiplier, one multiplier bit per cycle
module odo_serial_mult #(
	parameter int A_W = 34,
	parameter int B_W = 17
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [A_W-1:0]    a,
	input  logic signed [B_W-1:0]    b,
	output logic                     done,
	output logic signed [A_W+B_W-1:0] product
);
	localparam int P_W = A_W + B_W;
	localparam int CNT_W = $clog2(B_W);

	logic signed [P_W-1:0] a_q;
	logic signed [P_W-1:0] acc_q;
	logic [B_W-1:0]        b_q;
	logic [CNT_W-1:0]      cnt_q;
	logic                  busy_q;
	logic                  done_q;
	logic                  last_bit;

	assign last_bit = (cnt_q == CNT_W'(B_W - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last_bit) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// shift-add datapath, sign bit of b carries negative weight
	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= P_W'(a);
			b_q <= b;
			acc_q <= '0;
		end else if (busy_q) begin
			if (b_q[0]) begin
				acc_q <= last_bit ? acc_q - a_q : acc_q + a_q;
			end
			a_q <= a_q <<< 1;
			b_q <= b_q >> 1;
		end
	end

	assign done = done_q;
	assign product = acc_q;
endmodule

// ----- design/odo_cordic.sv -----
// iterative rotation cordic giving cos and sin of a binary angle
module odo_cordic #(
	parameter int ANGLE_BITS = odo_pkg::ANGLE_BITS_DEF,
	parameter int CORDIC_ITERATIONS = odo_pkg::CORDIC_ITERATIONS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [ANGLE_BITS-1:0]                angle,
	output logic                                 done,
	output logic signed [odo_pkg::CORDIC_W-1:0]  cos_out,
	output logic signed [odo_pkg::CORDIC_W-1:0]  sin_out
);
	import odo_pkg::*;

	localparam int IT_W = $clog2(CORDIC_ITERATIONS);

	logic signed [CORDIC_W-1:0] x_q, y_q, z_q;
	logic [1:0]                 quad_q;
	logic [IT_W-1:0]            iter_q;
	logic                       busy_q;
	logic                       done_q;
	logic [31:0]                turn_a, turn_t, turn_r;
	logic signed [CORDIC_W-1:0] xs, ys, at;
	logic                       last_it;

	// quadrant reduction of the widened angle
	assign turn_a = {angle, {(32 - ANGLE_BITS){1'b0}}};
	assign turn_t = turn_a + 32'h2000_0000;
	assign turn_r = turn_a - {turn_t[31:30], 30'd0};

	assign xs = x_q >>> iter_q;
	assign ys = y_q >>> iter_q;
	assign at = CORDIC_W'(atan_turn(ATAN_IDX_W'(iter_q)));
	assign last_it = (iter_q == IT_W'(CORDIC_ITERATIONS - 1));

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			iter_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				iter_q <= '0;
			end else if (busy_q) begin
				iter_q <= iter_q + 1'b1;
				if (last_it) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// micro-rotations
	always_ff @(posedge clk) begin
		if (start) begin
			x_q <= CORDIC_K;
			y_q <= '0;
			z_q <= CORDIC_W'($signed(turn_r));
			quad_q <= turn_t[31:30];
		end else if (busy_q) begin
			if (!z_q[CORDIC_W-1]) begin
				x_q <= x_q - ys;
				y_q <= y_q + xs;
				z_q <= z_q - at;
			end else begin
				x_q <= x_q + ys;
				y_q <= y_q - xs;
				z_q <= z_q + at;
			end
		end
	end

	// quadrant restore
	always_comb begin
		case (quad_q)
			2'd0: begin cos_out = x_q;  sin_out = y_q;  end
			2'd1: begin cos_out = -y_q; sin_out = x_q;  end
			2'd2: begin cos_out = -x_q; sin_out = -y_q; end
			default: begin cos_out = y_q; sin_out = -x_q; end
		endcase
	end

	assign done = done_q;
endmodule
